@@ hdl/tcls_pkg.sv @@
package tcls_pkg;

    localparam logic [7:0] HOLD_FOREVER = 8'hFF;
    localparam logic [7:0] SKIP_PHASE   = 8'h00;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ORDER_GRB = 3'd0,
        ORDER_RGB = 3'd1,
        ORDER_GBR = 3'd2,
        ORDER_RBG = 3'd3,
        ORDER_BRG = 3'd4,
        ORDER_BGR = 3'd5
    } order_t;

    localparam logic [1:0] PHASE_OFF    = 2'd0;
    localparam logic [1:0] PHASE_FIRST  = 2'd1;
    localparam logic [1:0] PHASE_SECOND = 2'd2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    localparam color_t RESET_COLOR = '{red: 8'hFF, green: 8'h00, blue: 8'h00};
    localparam color_t DARK_COLOR  = '{red: 8'h00, green: 8'h00, blue: 8'h00};

    // one request as held in the input register
    typedef struct packed {
        op_t        operation;
        color_t     first_color;
        logic [7:0] first_time;
        color_t     second_color;
        logic [7:0] second_time;
        logic [2:0] order_code;
    } req_t;

    // one result
    typedef struct packed {
        color_t     color;
        logic [2:0] channel_order;
        logic [1:0] phase;
        logic       counting;
    } rsp_t;

    // running phase state
    typedef struct packed {
        logic       active;
        logic [7:0] count;
        color_t     color;
        logic [1:0] phase;
    } run_t;

    localparam run_t RESET_RUN = '{
        active: 1'b0,
        count:  8'h00,
        color:  RESET_COLOR,
        phase:  PHASE_FIRST
    };

    // start phase one or two, or go dark when the phase is skipped
    function automatic run_t enter_phase(logic [1:0] which, color_t color,
                                         logic [7:0] duration);
        run_t r;
        if (duration == SKIP_PHASE)
        begin
            r = '{active: 1'b0, count: 8'h00, color: DARK_COLOR, phase: PHASE_OFF};
        end
        else if (duration == HOLD_FOREVER)
        begin
            r = '{active: 1'b0, count: 8'h00, color: color, phase: which};
        end
        else
        begin
            r = '{active: 1'b1, count: duration, color: color, phase: which};
        end
        return r;
    endfunction

    // codes beyond the last order fall back to grb
    function automatic logic [2:0] clean_order(logic [2:0] code);
        logic [2:0] r;
        if (code <= ORDER_BGR)
        begin
            r = code;
        end
        else
        begin
            r = ORDER_GRB;
        end
        return r;
    endfunction

endpackage

@@ hdl/tcls_req_if.sv @@
interface tcls_req_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] first_red;
    logic [7:0] first_green;
    logic [7:0] first_blue;
    logic [7:0] first_time;
    logic [7:0] second_red;
    logic [7:0] second_green;
    logic [7:0] second_blue;
    logic [7:0] second_time;
    logic [2:0] order_code;

    modport source (
        output valid, operation, first_red, first_green, first_blue, first_time,
               second_red, second_green, second_blue, second_time, order_code,
        input  ready
    );

    modport sink (
        input  valid, operation, first_red, first_green, first_blue, first_time,
               second_red, second_green, second_blue, second_time, order_code,
        output ready
    );
endinterface

@@ hdl/tcls_rsp_if.sv @@
interface tcls_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] shown_red;
    logic [7:0] shown_green;
    logic [7:0] shown_blue;
    logic [2:0] channel_order;
    logic [1:0] phase;
    logic       counting;

    modport source (
        output valid, shown_red, shown_green, shown_blue, channel_order, phase,
               counting,
        input  ready
    );

    modport sink (
        input  valid, shown_red, shown_green, shown_blue, channel_order, phase,
               counting,
        output ready
    );
endinterface

@@ hdl/tcls_in_stage.sv @@
module tcls_in_stage
    import tcls_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tcls_req_if.sink   req,
    input  logic       advance,
    output logic       item_valid,
    output req_t       item
);

    logic valid_reg;
    logic valid_next;
    req_t item_reg;
    logic take;

    assign req.ready = !valid_reg || advance;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.operation    <= op_t'(req.operation);
            item_reg.first_color  <= '{red: req.first_red, green: req.first_green,
                                       blue: req.first_blue};
            item_reg.first_time   <= req.first_time;
            item_reg.second_color <= '{red: req.second_red, green: req.second_green,
                                       blue: req.second_blue};
            item_reg.second_time  <= req.second_time;
            item_reg.order_code   <= req.order_code;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ hdl/tcls_core.sv @@
module tcls_core
    import tcls_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic fire,
    input  req_t item,
    output rsp_t result
);

    color_t     first_color_reg;
    color_t     first_color_next;
    color_t     second_color_reg;
    color_t     second_color_next;
    logic [7:0] first_dur_reg;
    logic [7:0] first_dur_next;
    logic [7:0] second_dur_reg;
    logic [7:0] second_dur_next;
    logic [2:0] order_reg;
    logic [2:0] order_next;
    run_t       run_reg;
    run_t       run_next;

    always_comb
    begin
        first_color_next  = first_color_reg;
        second_color_next = second_color_reg;
        first_dur_next    = first_dur_reg;
        second_dur_next   = second_dur_reg;
        order_next        = order_reg;
        run_next          = run_reg;

        if (item.operation == OP_LOAD)
        begin
            first_color_next  = item.first_color;
            second_color_next = item.second_color;
            first_dur_next    = item.first_time;
            second_dur_next   = item.second_time;
            order_next        = clean_order(item.order_code);
            if (item.first_time != SKIP_PHASE)
            begin
                run_next = enter_phase(PHASE_FIRST, item.first_color, item.first_time);
            end
            else
            begin
                run_next = enter_phase(PHASE_SECOND, item.second_color, item.second_time);
            end
        end
        else if (run_reg.active)
        begin
            priority if (run_reg.count > 8'd1)
            begin
                run_next.count = run_reg.count - 8'd1;
            end
            else if (run_reg.phase == PHASE_FIRST)
            begin
                run_next = enter_phase(PHASE_SECOND, second_color_reg, second_dur_reg);
            end
            else if (run_reg.phase == PHASE_SECOND)
            begin
                run_next = enter_phase(PHASE_FIRST, first_color_reg, first_dur_reg);
            end
            else
            begin
                run_next.active = 1'b0;
                run_next.count  = 8'h00;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_color_reg  <= DARK_COLOR;
            second_color_reg <= DARK_COLOR;
            first_dur_reg    <= SKIP_PHASE;
            second_dur_reg   <= SKIP_PHASE;
            order_reg        <= ORDER_GRB;
            run_reg          <= RESET_RUN;
        end
        else if (fire)
        begin
            first_color_reg  <= first_color_next;
            second_color_reg <= second_color_next;
            first_dur_reg    <= first_dur_next;
            second_dur_reg   <= second_dur_next;
            order_reg        <= order_next;
            run_reg          <= run_next;
        end
    end

    assign result = '{color:         run_next.color,
                      channel_order: order_next,
                      phase:         run_next.phase,
                      counting:      run_next.active};

    a_off_not_counting: assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg.phase == PHASE_OFF) |-> !run_reg.active)
        else $error("countdown running while led is off");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg.active |-> (run_reg.count != 8'h00 && run_reg.count != HOLD_FOREVER))
        else $error("running countdown holds a skip or hold value");

    a_load_first: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.operation == OP_LOAD && item.first_time != SKIP_PHASE)
        |=> (run_reg.phase == PHASE_FIRST && run_reg.color == $past(item.first_color)))
        else $error("load did not start the first phase");

    a_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.operation == OP_TICK && !run_reg.active) |=> $stable(run_reg))
        else $error("tick changed state with no countdown running");

endmodule

@@ hdl/tcls_out_stage.sv @@
module tcls_out_stage
    import tcls_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  rsp_t       result,
    output logic       advance,
    tcls_rsp_if.source rsp
);

    logic valid_reg;
    logic valid_next;
    rsp_t result_reg;

    assign advance = !valid_reg || rsp.ready;

    always_comb
    begin
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result;
        end
    end

    assign rsp.valid         = valid_reg;
    assign rsp.shown_red     = result_reg.color.red;
    assign rsp.shown_green   = result_reg.color.green;
    assign rsp.shown_blue    = result_reg.color.blue;
    assign rsp.channel_order = result_reg.channel_order;
    assign rsp.phase         = result_reg.phase;
    assign rsp.counting      = result_reg.counting;

endmodule

@@ hdl/two_color_timed_led_sequencer.sv @@
// an accepted request waits in the input register, then commits to the core state and
// is written into the result register together, once that register has room
// throughput: one request per cycle, limited only by the result register draining
// the sequencer state updates in a single pass between input and result registers
// reset: asynchronous, active low; led shows full red in the first color phase,
// stored colors and durations are zero, no countdown runs, order is grb
module two_color_timed_led_sequencer
    import tcls_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tcls_req_if.sink   req,
    tcls_rsp_if.source rsp
);

    logic item_valid;
    req_t item;
    logic advance;
    logic fire;
    rsp_t result;

    // input register: takes a new request when empty or whenever the held one moves on
    tcls_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // a held request commits to state when the result register has room
    assign fire = item_valid && advance;

    // stored colors, durations, order and the running phase countdown
    tcls_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .result (result)
    );

    // result register: drains on rsp ready and refills in the same cycle
    tcls_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .result  (result),
        .advance (advance),
        .rsp     (rsp)
    );

endmodule

@@ dv/tb_two_color_timed_led_sequencer.sv @@
`timescale 1ns / 1ps

module tb_two_color_timed_led_sequencer;
    import tcls_pkg::*;

    // order codes past the last defined order, stored as grb by the block
    localparam logic [2:0] ORDER_SPARE_LO = 3'd6;
    localparam logic [2:0] ORDER_SPARE_HI = 3'd7;

    // cycles with no request or result moving before the run is called stuck
    localparam int STALL_LIMIT = 2000;
    // settle time after the last result
    localparam int TAIL_CYCLES = 8;
    // random requests wanted after the directed ones
    localparam int RANDOM_ITEMS = 500;
    // every so often the sender holds a request until the block has drained
    localparam int DRAIN_EVERY = 120;

    // one request as the sender holds it
    typedef struct {
        op_t        operation;
        color_t     first;
        logic [7:0] first_time;
        color_t     second;
        logic [7:0] second_time;
        logic [2:0] order_code;
        bit         drain;
    } led_cmd_t;

    // one result as the led shows it
    typedef struct packed {
        color_t     color;
        logic [2:0] order;
        logic [1:0] phase;
        logic       counting;
    } led_view_t;

    logic clk;
    logic rst_n;

    tcls_req_if req_bus ();
    tcls_rsp_if rsp_bus ();

    two_color_timed_led_sequencer uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // requests waiting to be driven, and results owed by the block
    led_cmd_t  cmd_queue[$];
    led_view_t led_expect[$];

    int sent_count   = 0;
    int taken_count  = 0;
    int quiet_cycles = 0;
    int bad_count    = 0;

    // sender burst shaping
    int burst_left = 1;
    int gap_left   = 0;

    // receiver stall pattern
    int ready_tick = 0;
    int ready_mode = 0;

    // shadow of the sequencer, starts in the reset state
    color_t     held_first       = DARK_COLOR;
    color_t     held_second      = DARK_COLOR;
    logic [7:0] held_first_time  = SKIP_PHASE;
    logic [7:0] held_second_time = SKIP_PHASE;
    logic [2:0] held_order       = ORDER_GRB;
    logic [1:0] lit_phase        = PHASE_FIRST;
    logic       lit_running      = 1'b0;
    logic [7:0] lit_count        = 8'h00;
    color_t     lit_color        = RESET_COLOR;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // switch the shadow into phase one or two, dark when that phase is skipped
    function automatic void start_phase(logic [1:0] which, color_t color,
                                        logic [7:0] ticks);
        if (ticks == SKIP_PHASE)
        begin
            lit_running = 1'b0;
            lit_count   = 8'h00;
            lit_color   = DARK_COLOR;
            lit_phase   = PHASE_OFF;
        end
        else
        begin
            lit_color = color;
            lit_phase = which;
            // a held phase keeps its color with no countdown behind it
            lit_running = (ticks != HOLD_FOREVER);
            lit_count   = (ticks != HOLD_FOREVER) ? ticks : 8'h00;
        end
    endfunction

    // advance the shadow by one request and return what the led shows after it
    function automatic led_view_t predict_led(led_cmd_t cmd);
        led_view_t view;
        if (cmd.operation == OP_LOAD)
        begin
            held_order       = (cmd.order_code <= ORDER_BGR) ? cmd.order_code : ORDER_GRB;
            held_first       = cmd.first;
            held_first_time  = cmd.first_time;
            held_second      = cmd.second;
            held_second_time = cmd.second_time;
            // a skipped first phase starts straight in the second one
            if (held_first_time != SKIP_PHASE)
                start_phase(PHASE_FIRST, held_first, held_first_time);
            else
                start_phase(PHASE_SECOND, held_second, held_second_time);
        end
        else if (lit_running)
        begin
            // the tick that brings the count to zero flips the phase
            if (lit_count > 8'd1)
                lit_count = lit_count - 8'd1;
            else if (lit_phase == PHASE_FIRST)
                start_phase(PHASE_SECOND, held_second, held_second_time);
            else if (lit_phase == PHASE_SECOND)
                start_phase(PHASE_FIRST, held_first, held_first_time);
            else
            begin
                lit_running = 1'b0;
                lit_count   = 8'h00;
            end
        end
        // a tick with no countdown running leaves everything as it was
        view.color    = lit_color;
        view.order    = held_order;
        view.phase    = lit_phase;
        view.counting = lit_running;
        return view;
    endfunction

    function automatic led_cmd_t make_load(color_t first, logic [7:0] first_time,
                                           color_t second, logic [7:0] second_time,
                                           logic [2:0] order_code);
        led_cmd_t cmd;
        cmd.operation   = OP_LOAD;
        cmd.first       = first;
        cmd.first_time  = first_time;
        cmd.second      = second;
        cmd.second_time = second_time;
        cmd.order_code  = order_code;
        cmd.drain       = 1'b0;
        return cmd;
    endfunction

    // a tick carries junk in the fields the block ignores
    function automatic led_cmd_t make_tick();
        led_cmd_t cmd;
        cmd = make_load(color_t'($urandom_range(0, 24'hFFFFFF)), 8'($urandom_range(0, 255)),
                        color_t'($urandom_range(0, 24'hFFFFFF)), 8'($urandom_range(0, 255)),
                        3'($urandom_range(0, 7)));
        cmd.operation = OP_TICK;
        return cmd;
    endfunction

    function automatic led_cmd_t make_random_load(logic [7:0] first_time,
                                                  logic [7:0] second_time);
        return make_load(color_t'($urandom_range(0, 24'hFFFFFF)), first_time,
                         color_t'($urandom_range(0, 24'hFFFFFF)), second_time,
                         3'($urandom_range(0, 7)));
    endfunction

    // mostly short phases so the random part keeps cycling both colors
    function automatic logic [7:0] pick_duration();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 8'($urandom_range(1, 4));
        else if (roll < 65)
            return SKIP_PHASE;
        else if (roll < 75)
            return HOLD_FOREVER;
        else if (roll < 90)
            return 8'($urandom_range(5, 16));
        else if (roll < 97)
            return 8'($urandom_range(0, 255));
        else
            return 8'($urandom_range(200, 254));
    endfunction

    // the sender holds some requests back until nothing is owed
    function automatic void queue_cmd(led_cmd_t cmd);
        cmd.drain = (cmd_queue.size() % DRAIN_EVERY == DRAIN_EVERY / 2);
        cmd_queue.push_back(cmd);
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            bad_count++;
        end
    endtask

    // request driver: bursts of random length with random gaps between them,
    // a request stays on the bus until the monitor has seen it taken
    always @(negedge clk)
    begin : drive_req
        led_cmd_t next_cmd;
        if (rst_n)
        begin
            if (sent_count == taken_count)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (cmd_queue.size() != 0
                         && !(cmd_queue[0].drain && led_expect.size() != 0))
                begin
                    next_cmd = cmd_queue.pop_front();
                    req_bus.operation    <= next_cmd.operation;
                    req_bus.first_red    <= next_cmd.first.red;
                    req_bus.first_green  <= next_cmd.first.green;
                    req_bus.first_blue   <= next_cmd.first.blue;
                    req_bus.first_time   <= next_cmd.first_time;
                    req_bus.second_red   <= next_cmd.second.red;
                    req_bus.second_green <= next_cmd.second.green;
                    req_bus.second_blue  <= next_cmd.second.blue;
                    req_bus.second_time  <= next_cmd.second_time;
                    req_bus.order_code   <= next_cmd.order_code;
                    sent_count++;
                    // end of burst: pick the next length and maybe a gap
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
            end
            req_bus.valid <= (sent_count != taken_count);
        end
    end

    // result receiver: a stall pattern that is picked anew at random, ranging
    // from always ready to long stretches of back-pressure
    always @(negedge clk)
    begin : drive_ready
        logic take;
        if (ready_tick % 64 == 0)
            ready_mode = $urandom_range(0, 3);
        case (ready_mode)
            0:       take = 1'b1;
            1:       take = 1'($urandom_range(0, 1));
            2:       take = (ready_tick % 4 == 0);
            default: take = (ready_tick % 16 >= 12);
        endcase
        ready_tick++;
        rsp_bus.ready <= take;
    end

    // monitor: results are checked against the oldest expectation, and each
    // request taken by the block is run through the shadow right away
    always @(posedge clk)
    begin : watch_bus
        led_view_t want;
        led_cmd_t  seen;
        bit        moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                moved = 1'b1;
                if (led_expect.size() == 0)
                begin
                    $error("result with no request behind it");
                    bad_count++;
                end
                else
                begin
                    want = led_expect.pop_front();
                    check_field("shown_red", want.color.red, rsp_bus.shown_red);
                    check_field("shown_green", want.color.green, rsp_bus.shown_green);
                    check_field("shown_blue", want.color.blue, rsp_bus.shown_blue);
                    check_field("channel_order", want.order, rsp_bus.channel_order);
                    check_field("phase", want.phase, rsp_bus.phase);
                    check_field("counting", want.counting, rsp_bus.counting);
                end
            end
            if (req_bus.valid && req_bus.ready)
            begin
                moved            = 1'b1;
                seen.operation   = op_t'(req_bus.operation);
                seen.first       = {req_bus.first_red, req_bus.first_green, req_bus.first_blue};
                seen.first_time  = req_bus.first_time;
                seen.second      = {req_bus.second_red, req_bus.second_green,
                                    req_bus.second_blue};
                seen.second_time = req_bus.second_time;
                seen.order_code  = req_bus.order_code;
                seen.drain       = 1'b0;
                led_expect.push_back(predict_led(seen));
                taken_count++;
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    initial
    begin
        logic [7:0] dur_a;
        logic [7:0] dur_b;
        int         run_sum;
        int         tick_cap;
        int         n_ticks;
        int         start_size;

        clk                  = 1'b0;
        rst_n                = 1'b0;
        req_bus.valid        = 1'b0;
        req_bus.operation    = OP_TICK;
        req_bus.first_red    = 8'h00;
        req_bus.first_green  = 8'h00;
        req_bus.first_blue   = 8'h00;
        req_bus.first_time   = 8'h00;
        req_bus.second_red   = 8'h00;
        req_bus.second_green = 8'h00;
        req_bus.second_blue  = 8'h00;
        req_bus.second_time  = 8'h00;
        req_bus.order_code   = ORDER_GRB;
        rsp_bus.ready        = 1'b0;

        // --- directed part ---
        // tick out of reset: nothing counting, led still full red
        queue_cmd(make_tick());
        // all ones, both phases held, undefined order falls back to grb
        queue_cmd(make_load(24'hFFFFFF, HOLD_FOREVER, 24'hFFFFFF, HOLD_FOREVER,
                            ORDER_SPARE_HI));
        queue_cmd(make_tick());
        // both phases skipped: dark, no countdown, other undefined order
        queue_cmd(make_load(24'h000000, SKIP_PHASE, 24'h000000, SKIP_PHASE,
                            ORDER_SPARE_LO));
        queue_cmd(make_tick());
        // first skipped: second phase runs, then goes dark on expiry
        queue_cmd(make_load(24'h123456, SKIP_PHASE, 24'h9ABCDE, 8'd2, ORDER_BGR));
        queue_cmd(make_tick());
        queue_cmd(make_tick());
        // one-tick phases flip on every tick
        queue_cmd(make_load(24'hAA55AA, 8'd1, 24'h55AA55, 8'd1, ORDER_RGB));
        queue_cmd(make_tick());
        queue_cmd(make_tick());
        queue_cmd(make_tick());
        // hold entered after a transition stops the countdown
        queue_cmd(make_load(24'h01807F, 8'd2, 24'hFE0180, HOLD_FOREVER, ORDER_GBR));
        queue_cmd(make_tick());
        queue_cmd(make_tick());
        queue_cmd(make_tick());
        // second skipped: first phase expires into dark
        queue_cmd(make_load(24'h804020, 8'd1, 24'h100804, SKIP_PHASE, ORDER_RBG));
        queue_cmd(make_tick());
        // reload in the middle of a countdown, then the longest counted phase
        queue_cmd(make_load(24'hF00FC3, 8'd3, 24'h3C9669, 8'd1, ORDER_BRG));
        queue_cmd(make_tick());
        queue_cmd(make_load(24'h7F7F7F, 8'd1, 24'h808080, 8'hFE, ORDER_GRB));
        queue_cmd(make_tick());
        queue_cmd(make_tick());

        // --- random part ---
        // each load is followed by a random number of ticks, up to enough to walk its
        // phases, so many loads are cut short by the next one; now and then stray ticks
        start_size = cmd_queue.size();
        while (cmd_queue.size() - start_size < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                n_ticks = $urandom_range(1, 4);
                repeat (n_ticks) queue_cmd(make_tick());
            end
            dur_a   = pick_duration();
            dur_b   = pick_duration();
            queue_cmd(make_random_load(dur_a, dur_b));
            run_sum = 2;
            if (dur_a != SKIP_PHASE && dur_a != HOLD_FOREVER)
                run_sum += dur_a;
            if (dur_b != SKIP_PHASE && dur_b != HOLD_FOREVER)
                run_sum += dur_b;
            // long phases only sometimes get to run to the end
            tick_cap = (run_sum > 40 && $urandom_range(0, 1) == 1) ? 300 : 40;
            n_ticks  = $urandom_range(0, (run_sum < tick_cap) ? run_sum : tick_cap);
            repeat (n_ticks) queue_cmd(make_tick());
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // run until every request is in and every result is back, or stuck
        while ((cmd_queue.size() != 0 || sent_count != taken_count || led_expect.size() != 0)
               && quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        if (quiet_cycles < STALL_LIMIT)
            repeat (TAIL_CYCLES) @(posedge clk);
        if (led_expect.size() != 0)
        begin
            $error("%0d results never arrived", led_expect.size());
            bad_count++;
        end

        if (quiet_cycles < STALL_LIMIT && bad_count == 0)
            $display("two_color_timed_led_sequencer: match");
        else
            $display("two_color_timed_led_sequencer: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/tcls_pkg.sv
hdl/tcls_req_if.sv
hdl/tcls_rsp_if.sv
hdl/tcls_in_stage.sv
hdl/tcls_core.sv
hdl/tcls_out_stage.sv
hdl/two_color_timed_led_sequencer.sv
dv/tb_two_color_timed_led_sequencer.sv
